// ----- hdl/utf16_to_codepoint_decoder_top_defines.svh -----
// Assertion macros shared by the decoder's assertion sections.
`ifndef UTF16_TO_CODEPOINT_DECODER_TOP_DEFINES_SVH
`define UTF16_TO_CODEPOINT_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16D_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u16d check failed");

// The expression must never be true.
`define U16D_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("u16d check failed");

`endif

// ----- hdl/u16d_pkg.sv -----
`default_nettype none

package u16d_pkg;

   typedef enum logic [1:0] {
      ST_CODE_POINT   = 2'd0,
      ST_SURROGATE    = 2'd1,
      ST_TRUNCATED    = 2'd2
   } status_type;

   localparam logic [4:0]  SURR_PREFIX  = 5'b11011;
   localparam logic [5:0]  LOW_PREFIX   = 6'b110111;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [20:0] MAX_CODE     = 21'h10FFFF;

   typedef struct packed {
      logic [20:0] code_point;
      status_type  status;
   } res_type;

   typedef struct packed {
      logic [1:0] count;
      logic       buffer_end;
      res_type    res0;
      res_type    res1;
   } job_type;

   function automatic res_type make_res(logic [20:0] cp, status_type st);
      res_type r;
      r.code_point = cp;
      r.status     = st;
      return r;
   endfunction

   function automatic job_type job_add(job_type j, res_type r);
      job_type o;
      o = j;
      if (j.count == 2'd0) begin
         o.res0 = r;
      end else begin
         o.res1 = r;
      end
      o.count = j.count + 2'd1;
      return o;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/u16d_front.sv -----
`default_nettype none

module u16d_front
   import u16d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_buffer_end,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   output logic            push,
   output job_type         push_job
);

   logic        big_endian_ff, big_endian_in;
   logic        odd_ff, odd_in;
   logic [7:0]  held_ff, held_in;
   logic        hp_ff, hp_in;
   logic [9:0]  hb_ff, hb_in;
   logic [15:0] unit;
   logic        accept;
   job_type     job;

   assign accept = req_valid && !req_stall;

   always_comb begin
      unit = big_endian_ff ? {held_ff, req_data_byte} : {req_data_byte, held_ff};
      odd_in  = odd_ff;
      held_in = held_ff;
      hp_in   = hp_ff;
      hb_in   = hb_ff;
      job     = '0;
      job.buffer_end = req_buffer_end;
      if (!odd_ff) begin
         odd_in  = 1'b1;
         held_in = req_data_byte;
      end else begin
         odd_in = 1'b0;
         if (hp_ff && unit[15:10] == LOW_PREFIX) begin
            hp_in = 1'b0;
            job = job_add(job, make_res((SUPP_BASE + {1'b0, hb_ff, 10'b0})
                                        | {11'b0, unit[9:0]}, ST_CODE_POINT));
         end else begin
            if (hp_ff) begin
               hp_in = 1'b0;
               job = job_add(job, make_res('0, ST_SURROGATE));
            end
            if (unit[15:11] != SURR_PREFIX) begin
               job = job_add(job, make_res({5'b0, unit}, ST_CODE_POINT));
            end else if (unit[10]) begin
               job = job_add(job, make_res('0, ST_SURROGATE));
            end else begin
               hp_in = 1'b1;
               hb_in = unit[9:0];
            end
         end
      end
      if (req_buffer_end && (odd_in || hp_in)) begin
         job = job_add(job, make_res('0, ST_TRUNCATED));
         odd_in = 1'b0;
         hp_in  = 1'b0;
      end
   end

   always_comb begin
      big_endian_in = csr_wr_en ? csr_wr_data : big_endian_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
         odd_ff        <= 1'b0;
         hp_ff         <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
         if (accept) begin
            odd_ff <= odd_in;
            hp_ff  <= hp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
         hb_ff   <= hb_in;
      end
   end

   assign push     = accept && (job.count != 2'd0);
   assign push_job = job;

endmodule

`default_nettype wire

// ----- hdl/u16d_queue.sv -----
`default_nettype none

module u16d_queue
   import u16d_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   input  wire logic pop,
   output logic      full,
   output logic      head_valid,
   output job_type   head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/u16d_back.sv -----
`default_nettype none

module u16d_back
   import u16d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  job_type           head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [20:0]       rsp_code_point,
   output logic [1:0]        rsp_status,
   output logic              rsp_closes_buffer
);

   logic        valid_ff, valid_in;
   logic        sub_ff, sub_in;
   res_type     res_ff, res_in;
   logic        close_ff, close_in;
   logic        load;
   logic        last;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      last     = sub_ff || (head_job.count == 2'd1);
      valid_in = valid_ff;
      sub_in   = sub_ff;
      res_in   = res_ff;
      close_in = close_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            res_in   = sub_ff ? head_job.res1 : head_job.res0;
            close_in = head_job.buffer_end && last;
            pop      = last;
            sub_in   = !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      close_ff <= close_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_code_point    = res_ff.code_point;
   assign rsp_status        = res_ff.status;
   assign rsp_closes_buffer = close_ff;

endmodule

`default_nettype wire

// ----- hdl/utf16_to_codepoint_decoder_top.sv -----
// UTF-16 byte stream decoder. The req channel takes one stream byte per item
// together with a flag that marks the last byte of a buffer. The rsp channel
// gives code points, surrogate error results and truncation results, each
// with a flag on the final result of a buffer-end item. The csr port writes
// the byte order bit (1 is high byte first) and resets to big-endian order.
// The front stage pairs bytes, tracks a pending high surrogate and builds up
// to two results per item at once; these go into a small queue. The back
// stage sends one result per cycle through an output register while rsp is
// not stalled. An item is taken every cycle while the queue has room; its
// results pass through the queue, then the output register. An item that
// gives two results sends them one after the other. A stall on rsp holds
// the output register; the queue then fills and req is stalled. Reset
// clears the byte order to big-endian, drops any held byte or pending
// surrogate and empties the queue and the output register.
`default_nettype none
`include "utf16_to_codepoint_decoder_top_defines.svh"

module utf16_to_codepoint_decoder_top
   import u16d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_buffer_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_code_point,
   output logic [1:0]       rsp_status,
   output logic             rsp_closes_buffer,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   logic    push;
   job_type push_job;
   logic    pop;
   logic    full;
   logic    head_valid;
   job_type head_job;

   assign req_stall = full;

   u16d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_buffer_end (req_buffer_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .push           (push),
      .push_job       (push_job)
   );

   u16d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16d_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_status        (rsp_status),
      .rsp_closes_buffer (rsp_closes_buffer)
   );

   `U16D_ASSERT_IMPLIES(a_err_zero_cp, clock, reset,
      rsp_valid && rsp_status != ST_CODE_POINT, rsp_code_point == '0)
   `U16D_ASSERT_IMPLIES(a_truncated_closes, clock, reset,
      rsp_valid && rsp_status == ST_TRUNCATED, rsp_closes_buffer)
   `U16D_ASSERT_NEVER(a_cp_scalar, clock, reset,
      rsp_valid && rsp_status == ST_CODE_POINT &&
      (rsp_code_point > MAX_CODE || rsp_code_point[20:11] == {5'b0, SURR_PREFIX}))

endmodule

`default_nettype wire

// ----- dv/tb_utf16_to_codepoint_decoder_top.sv -----
`default_nettype none

module tb_utf16_to_codepoint_decoder_top;
   import u16d_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic [7:0] data_byte;
      logic       buffer_end;
   } stream_item_type;

   typedef struct packed {
      logic [20:0] code_point;
      status_type  status;
      logic        closes_buffer;
   } decoded_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_buffer_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic [1:0]  rsp_status;
   logic        rsp_closes_buffer;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   stream_item_type    byte_stream[$];
   logic [7:0]         buffer_bytes[$];
   decoded_result_type expected_points[$];

   logic       order_big_endian = 1'b1;
   logic       odd_held = 1'b0;
   logic [7:0] held_byte = 8'h00;
   logic       high_waiting = 1'b0;
   logic [9:0] high_bits = 10'h000;

   logic            drv_busy = 1'b0;
   int              drv_gap = 0;
   int              drv_calm = 0;
   int              stall_left = 0;
   int              stall_calm = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   stream_item_type next_item;

   utf16_to_codepoint_decoder_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_status        (rsp_status),
      .rsp_closes_buffer (rsp_closes_buffer),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic decoded_result_type make_result(logic [20:0] cp, status_type st);
      decoded_result_type r;
      r.code_point    = cp;
      r.status        = st;
      r.closes_buffer = 1'b0;
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic take_fresh_unit(input logic [15:0] unit);
      if (unit[15:11] != SURR_PREFIX) begin
         expected_points.push_back(make_result({5'b0, unit}, ST_CODE_POINT));
      end else if (unit[10]) begin
         expected_points.push_back(make_result(21'd0, ST_SURROGATE));
      end else begin
         high_waiting = 1'b1;
         high_bits    = unit[9:0];
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [15:0] unit;
      int          first;
      first = expected_points.size();
      if (!odd_held) begin
         odd_held  = 1'b1;
         held_byte = b;
      end else begin
         odd_held = 1'b0;
         unit = order_big_endian ? {held_byte, b} : {b, held_byte};
         if (high_waiting) begin
            high_waiting = 1'b0;
            if (unit[15:10] == LOW_PREFIX) begin
               expected_points.push_back(
                  make_result(SUPP_BASE + {high_bits, unit[9:0]}, ST_CODE_POINT));
            end else begin
               expected_points.push_back(make_result(21'd0, ST_SURROGATE));
               take_fresh_unit(unit);
            end
         end else begin
            take_fresh_unit(unit);
         end
      end
      if (last) begin
         if (odd_held || high_waiting) begin
            expected_points.push_back(make_result(21'd0, ST_TRUNCATED));
            odd_held     = 1'b0;
            high_waiting = 1'b0;
         end
         if (expected_points.size() > first) begin
            expected_points[expected_points.size() - 1].closes_buffer = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_buffer_end);
            drv_busy = 1'b0;
         end
         if (!drv_busy) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
               next_item = byte_stream.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= next_item.data_byte;
               req_buffer_end <= next_item.buffer_end;
               drv_busy = 1'b1;
               if (drv_calm > 0) begin
                  drv_calm--;
                  drv_gap = 0;
               end else begin
                  drv_gap = gap_len();
                  if ($urandom_range(0, 49) == 0) drv_calm = $urandom_range(30, 80);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      decoded_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: cp %h status %0d closes %b",
                           rsp_code_point, rsp_status, rsp_closes_buffer);
               end
            end else begin
               want = expected_points.pop_front();
               if (rsp_code_point !== want.code_point || rsp_status !== want.status ||
                   rsp_closes_buffer !== want.closes_buffer) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected cp %h st %0d cl %b, got cp %h st %0d cl %b",
                              want.code_point, want.status, want.closes_buffer,
                              rsp_code_point, rsp_status, rsp_closes_buffer);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_calm > 0) begin
               stall_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
               stall_left = gap_len();
               if ($urandom_range(0, 29) == 0) stall_calm = $urandom_range(40, 100);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf16_to_codepoint_decoder_top regression: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      stream_item_type it;
      it.data_byte  = b;
      it.buffer_end = last;
      byte_stream.push_back(it);
   endtask

   task automatic add_unit(input logic [15:0] unit, input logic be);
      if (be) begin
         buffer_bytes.push_back(unit[15:8]);
         buffer_bytes.push_back(unit[7:0]);
      end else begin
         buffer_bytes.push_back(unit[7:0]);
         buffer_bytes.push_back(unit[15:8]);
      end
   endtask

   task automatic queue_random_buffers(input logic be, input int n_bytes);
      int          start;
      int          units;
      int          kind;
      logic        with_end;
      logic [15:0] u;
      start = byte_stream.size();
      while (byte_stream.size() - start < n_bytes) begin
         buffer_bytes.delete();
         units = $urandom_range(1, 10);
         for (int i = 0; i < units; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
               do u = 16'($urandom_range(0, 16'hFFFF)); while (u[15:11] == SURR_PREFIX);
               add_unit(u, be);
            end else if (kind < 88) begin
               add_unit(16'hD800 | 16'($urandom_range(0, 1023)), be);
               add_unit(16'hDC00 | 16'($urandom_range(0, 1023)), be);
            end else if (kind < 92) begin
               add_unit(16'hDC00 | 16'($urandom_range(0, 1023)), be);
            end else if (kind < 96) begin
               add_unit(16'hD800 | 16'($urandom_range(0, 1023)), be);
            end else begin
               add_unit(16'($urandom_range(0, 16'hFFFF)), be);
            end
         end
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            buffer_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 14) begin
            add_unit(16'hD800 | 16'($urandom_range(0, 1023)), be);
         end
         with_end = ($urandom_range(0, 9) != 0);
         foreach (buffer_bytes[i]) begin
            send_byte(buffer_bytes[i], with_end && (i == buffer_bytes.size() - 1));
         end
      end
   endtask

   task automatic wait_idle();
      while (byte_stream.size() != 0 || drv_busy || expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_byte_order(input logic be);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= be;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_big_endian = be;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_byte_order(1'b1);
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hD8, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hDC, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hDB, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'hDF, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'hDC, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hD8, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h41, 1'b1);
      send_byte(8'hD8, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hDB, 1'b0); send_byte(8'h01, 1'b1);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hAB, 1'b0);
      wait_idle();

      // The held byte is paired under the new byte order.
      write_byte_order(1'b0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'hD8, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'hDC, 1'b1);
      send_byte(8'hFF, 1'b1);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         write_byte_order(p % 2 == 0);
         queue_random_buffers(p % 2 == 0, 215);
         wait_idle();
      end

      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("utf16_to_codepoint_decoder_top regression: pass");
      end else begin
         $display("utf16_to_codepoint_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
